### hdl/ttp_pkg.sv
// types, codes and constants shared by the tiered task placement unit
// no dependencies; used by ttp_cell, tiered_task_placement_unit and the dv files
package ttp_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int NUM_TIERS       = 3;    // edge, hub, compute take part in chains
    localparam int NUM_IDX         = NUM_TIERS + 1;  // one more for the first local slot

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_REMOVE  = 2'd1;
    localparam logic [1:0] MODE_RESOLVE = 2'd2;

    localparam logic [1:0] TIER_EDGE    = 2'd0;
    localparam logic [1:0] TIER_HUB     = 2'd1;
    localparam logic [1:0] TIER_COMPUTE = 2'd2;

    localparam logic [1:0] PRIV_NO_EGRESS  = 2'd1;
    localparam logic [1:0] PRIV_LOCAL_ONLY = 2'd2;

    localparam logic       CFG_HEAVY_LEVEL    = 1'b0;
    localparam logic       CFG_SHORT_DEADLINE = 1'b1;

    localparam logic [3:0]  HEAVY_LEVEL_RST    = 4'd8;
    localparam logic [15:0] SHORT_DEADLINE_RST = 16'd50;

    localparam int LOCAL_SLOT = NUM_TIERS;   // index lane of the first local slot

    typedef struct packed {
        logic [3:0] level;
        logic [6:0] load;
        logic       shared;
        logic       own_node;
        logic       peer;
        logic       reach;
        logic [1:0] tier;
    } slot_rec_t;

    typedef struct packed {
        logic       found;
        logic       peer;
        logic [6:0] load;
        logic [3:0] level;
    } tier_best_t;

    typedef struct packed {
        tier_best_t [NUM_TIERS-1:0] best;
        logic                       shared_compute;
        logic                       loc_found;
        logic                       loc_reach;
        logic [1:0]                 loc_tier;
    } scan_acc_t;

endpackage

### hdl/ttp_cell.sv
// one table slot of the placement unit: holds the slot record and folds it
// into the running scan accumulator; depends on ttp_pkg
module ttp_cell #(
    parameter int SLOT_ID = 0,
    parameter int IDX_W   = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic                                   rm_en,
    input  ttp_pkg::slot_rec_t                     wr_rec,
    input  logic                                   in_valid,
    input  ttp_pkg::scan_acc_t                     in_acc,
    input  logic [ttp_pkg::NUM_IDX-1:0][IDX_W-1:0] in_idx,
    output logic                                   out_valid,
    output ttp_pkg::scan_acc_t                     out_acc,
    output logic [ttp_pkg::NUM_IDX-1:0][IDX_W-1:0] out_idx
);

    logic                                   present_reg;
    ttp_pkg::slot_rec_t                     rec_reg;
    logic                                   valid_reg;
    ttp_pkg::scan_acc_t                     acc_reg;
    ttp_pkg::scan_acc_t                     acc_next;
    logic [ttp_pkg::NUM_IDX-1:0][IDX_W-1:0] idx_reg;
    logic [ttp_pkg::NUM_IDX-1:0][IDX_W-1:0] idx_next;
    logic                                   usable;
    logic                                   better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (wr_en)
            begin
                present_reg <= 1'b1;
            end
            else if (rm_en)
            begin
                present_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_reg <= wr_rec;
        end
        acc_reg <= acc_next;
        idx_reg <= idx_next;
    end

    always_comb
    begin
        acc_next = in_acc;
        idx_next = in_idx;
        usable   = present_reg && rec_reg.reach;
        better   = 1'b0;
        for (int t = 0; t < ttp_pkg::NUM_TIERS; t++)
        begin
            // non-peer wins, then strictly lower load; ties keep the earlier slot
            if (in_acc.best[t].peer != rec_reg.peer)
            begin
                better = !rec_reg.peer;
            end
            else
            begin
                better = rec_reg.load < in_acc.best[t].load;
            end
            if (usable && rec_reg.tier == 2'(t) && (!in_acc.best[t].found || better))
            begin
                acc_next.best[t].found = 1'b1;
                acc_next.best[t].peer  = rec_reg.peer;
                acc_next.best[t].load  = rec_reg.load;
                acc_next.best[t].level = rec_reg.level;
                idx_next[t]            = IDX_W'(SLOT_ID);
            end
        end
        if (present_reg && rec_reg.tier == ttp_pkg::TIER_COMPUTE && rec_reg.shared)
        begin
            acc_next.shared_compute = 1'b1;
        end
        // only the first present local slot counts, reachable or not
        if (present_reg && rec_reg.own_node && !in_acc.loc_found)
        begin
            acc_next.loc_found            = 1'b1;
            acc_next.loc_reach            = rec_reg.reach;
            acc_next.loc_tier             = rec_reg.tier;
            idx_next[ttp_pkg::LOCAL_SLOT] = IDX_W'(SLOT_ID);
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_idx   = idx_reg;

endmodule

### hdl/tiered_task_placement_unit.sv
// top level of the tiered task placement unit: item decode, config registers,
// the row of ttp_cell slots and the final tier chain check; depends on ttp_pkg
//
//  channel   handshake              payload
//  item in   start, busy            mode .. task_deadline_ms
//  result    done (strobe)          found, chosen_index, miss_policy
//  config    cfg_we                 cfg_index, cfg_data
//
// write and remove transactions update the slot on acceptance; busy stays low
// a resolve transaction passes go_reg, then the scan token walks the slot row one
// cell a cycle, then the chain check result is registered; busy is high meanwhile
// done pulses for one cycle with the result; the receiver cannot stall
// reset clears all slots and loads the config defaults
module tiered_task_placement_unit #(
    parameter int TABLE_SLOTS = ttp_pkg::TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  entry_index,
    input  logic [1:0]  node_tier,
    input  logic        node_reachable,
    input  logic        node_is_peer,
    input  logic        node_is_local,
    input  logic        node_shared,
    input  logic [6:0]  node_load,
    input  logic [3:0]  level,
    input  logic [1:0]  task_privacy,
    input  logic        task_has_deadline,
    input  logic [15:0] task_deadline_ms,
    output logic        done,
    output logic        found,
    output logic [3:0]  chosen_index,
    output logic        miss_policy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic        busy_reg;
    logic        go_reg;
    logic [3:0]  heavy_reg;
    logic [15:0] short_dl_reg;
    logic [3:0]  lvl_reg;
    logic [1:0]  priv_reg;
    logic        degrade_reg;
    logic        heavy_task_reg;
    logic        done_reg;
    logic        found_reg;
    logic [3:0]  chosen_reg;
    logic        miss_reg;

    logic               item_acc;
    logic               resolve_acc;
    ttp_pkg::slot_rec_t wr_rec;

    logic                                   valid_chain [TABLE_SLOTS+1];
    ttp_pkg::scan_acc_t                     acc_chain   [TABLE_SLOTS+1];
    logic [ttp_pkg::NUM_IDX-1:0][IDX_W-1:0] idx_chain   [TABLE_SLOTS+1];
    logic [TABLE_SLOTS:0]                   valid_vec;

    ttp_pkg::scan_acc_t                     fin_acc;
    logic [ttp_pkg::NUM_IDX-1:0][IDX_W-1:0] fin_idx;
    logic                                   fin_valid;
    logic                                   deny_hub;
    logic                                   deny_cmp;
    logic [ttp_pkg::NUM_TIERS-1:0]          tier_ok;
    logic                                   loc_ok;
    logic                                   found_next;
    logic [IDX_W-1:0]                       chosen_next;

    assign item_acc    = start && !busy_reg;
    assign resolve_acc = item_acc && mode == ttp_pkg::MODE_RESOLVE;

    always_comb
    begin
        wr_rec.level    = level;
        wr_rec.load     = node_load;
        wr_rec.shared   = node_shared;
        wr_rec.own_node = node_is_local;
        wr_rec.peer     = node_is_peer;
        wr_rec.reach    = node_reachable;
        wr_rec.tier     = node_tier;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heavy_reg    <= ttp_pkg::HEAVY_LEVEL_RST;
            short_dl_reg <= ttp_pkg::SHORT_DEADLINE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttp_pkg::CFG_HEAVY_LEVEL:    heavy_reg    <= cfg_data[3:0];
                ttp_pkg::CFG_SHORT_DEADLINE: short_dl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            go_reg   <= resolve_acc;
            done_reg <= fin_valid;
            if (resolve_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin_valid)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // task fields and policy class, captured per resolve transaction, and the result registers
    always_ff @(posedge clk)
    begin
        if (resolve_acc)
        begin
            lvl_reg        <= level;
            priv_reg       <= task_privacy;
            degrade_reg    <= task_privacy == ttp_pkg::PRIV_LOCAL_ONLY
                              || (task_has_deadline && task_deadline_ms < short_dl_reg);
            heavy_task_reg <= level >= heavy_reg;
        end
        if (fin_valid)
        begin
            found_reg  <= found_next;
            chosen_reg <= 4'(chosen_next);
            miss_reg   <= degrade_reg;
        end
    end

    assign valid_chain[0] = go_reg;
    assign acc_chain[0]   = '0;
    assign idx_chain[0]   = '0;

    for (genvar i = 0; i < TABLE_SLOTS; i++)
    begin : g_slot
        logic hit;
        assign hit = item_acc && 32'(entry_index) == i;

        ttp_cell #(
            .SLOT_ID (i),
            .IDX_W   (IDX_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (hit && mode == ttp_pkg::MODE_WRITE),
            .rm_en     (hit && mode == ttp_pkg::MODE_REMOVE),
            .wr_rec    (wr_rec),
            .in_valid  (valid_chain[i]),
            .in_acc    (acc_chain[i]),
            .in_idx    (idx_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_acc   (acc_chain[i+1]),
            .out_idx   (idx_chain[i+1])
        );
    end

    for (genvar j = 0; j <= TABLE_SLOTS; j++)
    begin : g_vvec
        assign valid_vec[j] = valid_chain[j];
    end

    assign fin_valid = valid_chain[TABLE_SLOTS];
    assign fin_acc   = acc_chain[TABLE_SLOTS];
    assign fin_idx   = idx_chain[TABLE_SLOTS];

    // tier chain check on the finished scan
    always_comb
    begin
        deny_hub = priv_reg == ttp_pkg::PRIV_LOCAL_ONLY;
        deny_cmp = deny_hub || (priv_reg == ttp_pkg::PRIV_NO_EGRESS && fin_acc.shared_compute);
        for (int t = 0; t < ttp_pkg::NUM_TIERS; t++)
        begin
            tier_ok[t] = fin_acc.best[t].found && fin_acc.best[t].level >= lvl_reg;
        end
        tier_ok[ttp_pkg::TIER_HUB]     = tier_ok[ttp_pkg::TIER_HUB] && !deny_hub;
        tier_ok[ttp_pkg::TIER_COMPUTE] = tier_ok[ttp_pkg::TIER_COMPUTE] && !deny_cmp;
        loc_ok = fin_acc.loc_found && fin_acc.loc_reach
                 && !(fin_acc.loc_tier == ttp_pkg::TIER_HUB && deny_hub)
                 && !(fin_acc.loc_tier == ttp_pkg::TIER_COMPUTE && deny_cmp);

        found_next  = 1'b0;
        chosen_next = '0;
        if (degrade_reg)
        begin
            if (tier_ok[ttp_pkg::TIER_EDGE])
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::TIER_EDGE];
            end
            else if (loc_ok)
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::LOCAL_SLOT];
            end
        end
        else if (heavy_task_reg)
        begin
            if (tier_ok[ttp_pkg::TIER_COMPUTE])
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::TIER_COMPUTE];
            end
            else if (tier_ok[ttp_pkg::TIER_HUB])
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::TIER_HUB];
            end
            else if (tier_ok[ttp_pkg::TIER_EDGE])
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::TIER_EDGE];
            end
        end
        else
        begin
            if (tier_ok[ttp_pkg::TIER_EDGE])
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::TIER_EDGE];
            end
            else if (tier_ok[ttp_pkg::TIER_HUB])
            begin
                found_next  = 1'b1;
                chosen_next = fin_idx[ttp_pkg::TIER_HUB];
            end
        end
    end

    assign busy         = busy_reg;
    assign done         = done_reg;
    assign found        = found_reg;
    assign chosen_index = chosen_reg;
    assign miss_policy  = miss_reg;

    // only one scan token in the slot row at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec))
        else $error("more than one scan token in the slot row");

    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (|valid_vec) |-> busy_reg)
        else $error("scan token present while not busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg) && !busy_reg)
        else $error("result strobe without a finished resolve");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> chosen_index == 4'd0)
        else $error("nonzero slot reported with no node found");

endmodule

### dv/ttp_placement_checker.sv
// checker for the tiered task placement unit: tracks the slot table and the
// config registers, predicts each placement and compares it with the result
// depends on ttp_pkg
`timescale 1ns / 1ps

module ttp_placement_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  entry_index,
    input  logic [1:0]  node_tier,
    input  logic        node_reachable,
    input  logic        node_is_peer,
    input  logic        node_is_local,
    input  logic        node_shared,
    input  logic [6:0]  node_load,
    input  logic [3:0]  level,
    input  logic [1:0]  task_privacy,
    input  logic        task_has_deadline,
    input  logic [15:0] task_deadline_ms,
    input  logic        done,
    input  logic        found,
    input  logic [3:0]  chosen_index,
    input  logic        miss_policy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int SLOTS = ttp_pkg::TABLE_SLOTS_DEF;

    typedef struct packed {
        logic       found;
        logic [3:0] index;
        logic       miss;
    } placement_t;

    logic               heavy_level_unused_guard;
    logic [3:0]         heavy_level;
    logic [15:0]        short_deadline;
    logic               present [SLOTS];
    ttp_pkg::slot_rec_t records [SLOTS];
    placement_t         expected_placements [$];
    int                 mismatch_total;

    assign heavy_level_unused_guard = 1'b0;
    assign fail_count    = mismatch_total + int'(heavy_level_unused_guard);
    assign pending_count = expected_placements.size();

    function automatic int best_in_tier(input logic [1:0] tier);
        int best = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (present[i] && records[i].tier == tier && records[i].reach)
            begin
                if (best < 0)
                    best = i;
                else if (records[best].peer != records[i].peer)
                begin
                    if (!records[i].peer)
                        best = i;
                end
                else if (records[i].load < records[best].load)
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic placement_t predict_placement(input logic [3:0] task_level,
                                                     input logic [1:0] privacy,
                                                     input logic dl_valid,
                                                     input logic [15:0] deadline);
        logic [1:0] chain [3];
        int         chain_len;
        logic       degrade;
        logic [3:0] denied;
        int         chosen;
        int         pick;
        int         first_local;
        placement_t res;
        degrade = 1'b0;
        denied  = '0;
        chosen  = -1;
        first_local = -1;
        if (privacy == ttp_pkg::PRIV_LOCAL_ONLY || (dl_valid && deadline < short_deadline))
        begin
            chain[0]  = ttp_pkg::TIER_EDGE;
            chain_len = 1;
            degrade   = 1'b1;
        end
        else if (task_level >= heavy_level)
        begin
            chain[0]  = ttp_pkg::TIER_COMPUTE;
            chain[1]  = ttp_pkg::TIER_HUB;
            chain[2]  = ttp_pkg::TIER_EDGE;
            chain_len = 3;
        end
        else
        begin
            chain[0]  = ttp_pkg::TIER_EDGE;
            chain[1]  = ttp_pkg::TIER_HUB;
            chain_len = 2;
        end

        if (privacy == ttp_pkg::PRIV_LOCAL_ONLY)
        begin
            denied[ttp_pkg::TIER_HUB]     = 1'b1;
            denied[ttp_pkg::TIER_COMPUTE] = 1'b1;
        end
        else if (privacy == ttp_pkg::PRIV_NO_EGRESS)
        begin
            // any shared compute entry blocks the tier, reachable or not
            for (int i = 0; i < SLOTS; i++)
                if (present[i] && records[i].tier == ttp_pkg::TIER_COMPUTE
                    && records[i].shared)
                    denied[ttp_pkg::TIER_COMPUTE] = 1'b1;
        end

        for (int k = 0; k < chain_len && chosen < 0; k++)
        begin
            if (!denied[chain[k]])
            begin
                pick = best_in_tier(chain[k]);
                if (pick >= 0 && records[pick].level >= task_level)
                    chosen = pick;
            end
        end

        if (chosen < 0 && degrade)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (first_local < 0 && present[i] && records[i].own_node)
                    first_local = i;
            // fallback ignores the node level
            if (first_local >= 0 && records[first_local].reach
                && !denied[records[first_local].tier])
                chosen = first_local;
        end

        res.found = (chosen >= 0);
        res.index = (chosen >= 0) ? 4'(chosen) : 4'd0;
        res.miss  = degrade;
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_total < 10)
            $display("%t mismatch: %s", $realtime, msg);
        mismatch_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            heavy_level    = ttp_pkg::HEAVY_LEVEL_RST;
            short_deadline = ttp_pkg::SHORT_DEADLINE_RST;
            for (int i = 0; i < SLOTS; i++)
                present[i] = 1'b0;
            expected_placements.delete();
            mismatch_total = 0;
        end
        else
        begin
            // the result of an older transaction comes first
            if (done)
            begin
                if (expected_placements.size() == 0)
                    log_mismatch($sformatf("result with no transaction pending: found=%0d index=%0d miss=%0d",
                                           found, chosen_index, miss_policy));
                else
                begin
                    want = expected_placements.pop_front();
                    if (found !== want.found || chosen_index !== want.index
                        || miss_policy !== want.miss)
                        log_mismatch($sformatf("expected found=%0d index=%0d miss=%0d, got found=%0d index=%0d miss=%0d",
                                               want.found, want.index, want.miss,
                                               found, chosen_index, miss_policy));
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == ttp_pkg::CFG_HEAVY_LEVEL)
                    heavy_level = cfg_data[3:0];
                else
                    short_deadline = cfg_data;
            end

            if (start && !busy)
            begin
                case (mode)
                    ttp_pkg::MODE_WRITE:
                    begin
                        if (int'(entry_index) < SLOTS)
                        begin
                            records[entry_index] = '{level: level, load: node_load,
                                                     shared: node_shared,
                                                     own_node: node_is_local,
                                                     peer: node_is_peer,
                                                     reach: node_reachable,
                                                     tier: node_tier};
                            present[entry_index] = 1'b1;
                        end
                    end
                    ttp_pkg::MODE_REMOVE:
                    begin
                        if (int'(entry_index) < SLOTS)
                            present[entry_index] = 1'b0;
                    end
                    ttp_pkg::MODE_RESOLVE:
                        expected_placements.push_back(predict_placement(level, task_privacy,
                                                                        task_has_deadline,
                                                                        task_deadline_ms));
                    default:
                        ;
                endcase
            end
        end
    end

endmodule

### dv/tiered_task_placement_unit_tb.sv
// testbench top for the tiered task placement unit: clock, reset, directed and
// random transactions, config phases and the verdict
// depends on ttp_pkg, tiered_task_placement_unit and ttp_placement_checker
`timescale 1ns / 1ps

module tiered_task_placement_unit_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] TIER_OTHER  = 2'd3;
    localparam logic [1:0] PRIV_OPEN   = 2'd0;
    localparam logic [1:0] PRIV_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int NUM_PHASES      = 6;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  idx;
        logic [1:0]  tier;
        logic        reach;
        logic        peer;
        logic        loc;
        logic        shared;
        logic [6:0]  load;
        logic [3:0]  lvl;
        logic [1:0]  priv;
        logic        has_dl;
        logic [15:0] dl;
    } task_item_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [3:0]  entry_index;
    logic [1:0]  node_tier;
    logic        node_reachable;
    logic        node_is_peer;
    logic        node_is_local;
    logic        node_shared;
    logic [6:0]  node_load;
    logic [3:0]  level;
    logic [1:0]  task_privacy;
    logic        task_has_deadline;
    logic [15:0] task_deadline_ms;
    logic        done;
    logic        found;
    logic [3:0]  chosen_index;
    logic        miss_policy;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_count;

    logic [15:0] cur_short;
    bit          bursty;
    int          burst_left;

    tiered_task_placement_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .entry_index       (entry_index),
        .node_tier         (node_tier),
        .node_reachable    (node_reachable),
        .node_is_peer      (node_is_peer),
        .node_is_local     (node_is_local),
        .node_shared       (node_shared),
        .node_load         (node_load),
        .level             (level),
        .task_privacy      (task_privacy),
        .task_has_deadline (task_has_deadline),
        .task_deadline_ms  (task_deadline_ms),
        .done              (done),
        .found             (found),
        .chosen_index      (chosen_index),
        .miss_policy       (miss_policy),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    ttp_placement_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .entry_index       (entry_index),
        .node_tier         (node_tier),
        .node_reachable    (node_reachable),
        .node_is_peer      (node_is_peer),
        .node_is_local     (node_is_local),
        .node_shared       (node_shared),
        .node_load         (node_load),
        .level             (level),
        .task_privacy      (task_privacy),
        .task_has_deadline (task_has_deadline),
        .task_deadline_ms  (task_deadline_ms),
        .done              (done),
        .found             (found),
        .chosen_index      (chosen_index),
        .miss_policy       (miss_policy),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .pending_count     (pending_count)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic task_item_t mk_entry(input logic [3:0] idx, input logic [1:0] tier,
                                            input logic reach, input logic peer,
                                            input logic loc, input logic shared,
                                            input logic [6:0] load, input logic [3:0] lvl);
        task_item_t it;
        it = '{mode: ttp_pkg::MODE_WRITE, idx: idx, tier: tier, reach: reach, peer: peer,
               loc: loc, shared: shared, load: load, lvl: lvl, priv: PRIV_OPEN,
               has_dl: 1'b0, dl: 16'd0};
        return it;
    endfunction

    function automatic task_item_t mk_task(input logic [3:0] lvl, input logic [1:0] priv,
                                           input logic has_dl, input logic [15:0] dl);
        task_item_t it;
        it = '{mode: ttp_pkg::MODE_RESOLVE, idx: 4'd0, tier: ttp_pkg::TIER_EDGE, reach: 1'b0,
               peer: 1'b0, loc: 1'b0, shared: 1'b0, load: 7'd0, lvl: lvl, priv: priv,
               has_dl: has_dl, dl: dl};
        return it;
    endfunction

    function automatic task_item_t random_item();
        task_item_t it;
        int roll;
        int dl_near;
        roll = $urandom_range(0, 99);
        if (roll < 38)
            it.mode = ttp_pkg::MODE_WRITE;
        else if (roll < 48)
            it.mode = ttp_pkg::MODE_REMOVE;
        else if (roll < 98)
            it.mode = ttp_pkg::MODE_RESOLVE;
        else
            it.mode = MODE_UNUSED;
        it.idx    = 4'($urandom_range(0, 15));
        it.tier   = ($urandom_range(0, 9) == 0) ? TIER_OTHER : 2'($urandom_range(0, 2));
        it.reach  = ($urandom_range(0, 3) != 0);
        it.peer   = 1'($urandom_range(0, 1));
        it.loc    = ($urandom_range(0, 4) == 0);
        it.shared = ($urandom_range(0, 3) == 0);
        it.load   = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(101, 127))
                                                : 7'($urandom_range(0, 100));
        it.lvl    = 4'($urandom_range(0, 15));
        it.priv   = ($urandom_range(0, 19) == 0) ? PRIV_UNUSED : 2'($urandom_range(0, 2));
        it.has_dl = 1'($urandom_range(0, 1));
        // half the deadlines sit right around the short deadline threshold
        dl_near = int'(cur_short) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1)
            it.dl = (dl_near < 0) ? 16'd0 : (dl_near > 65535) ? 16'hFFFF : 16'(dl_near);
        else
            it.dl = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic send_item(input task_item_t it);
        start             <= 1'b1;
        mode              <= it.mode;
        entry_index       <= it.idx;
        node_tier         <= it.tier;
        node_reachable    <= it.reach;
        node_is_peer      <= it.peer;
        node_is_local     <= it.loc;
        node_shared       <= it.shared;
        node_load         <= it.load;
        level             <= it.lvl;
        task_privacy      <= it.priv;
        task_has_deadline <= it.has_dl;
        task_deadline_ms  <= it.dl;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
    endtask

    // writes and removes leave no result, so keep waiting after the queue drains as well
    task automatic wait_idle();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [3:0] heavy, input logic [15:0] short_dl);
        cfg_we    <= 1'b1;
        cfg_index <= ttp_pkg::CFG_HEAVY_LEVEL;
        cfg_data  <= {16'($urandom_range(0, 4095)) << 4} | {12'd0, heavy};
        @(posedge clk);
        cfg_index <= ttp_pkg::CFG_SHORT_DEADLINE;
        cfg_data  <= short_dl;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_short = short_dl;
        @(posedge clk);
    endtask

    initial
    begin
        logic [3:0]  heavy_set [NUM_PHASES];
        logic [15:0] short_set [NUM_PHASES];
        heavy_set = '{4'd0, 4'd15, 4'd4, 4'd12, 4'd0, 4'd0};
        short_set = '{16'd0, 16'hFFFF, 16'd200, 16'd30, 16'd0, 16'd0};
        rst_n             = 1'b0;
        start             <= 1'b0;
        mode              <= ttp_pkg::MODE_WRITE;
        entry_index       <= '0;
        node_tier         <= ttp_pkg::TIER_EDGE;
        node_reachable    <= 1'b0;
        node_is_peer      <= 1'b0;
        node_is_local     <= 1'b0;
        node_shared       <= 1'b0;
        node_load         <= '0;
        level             <= '0;
        task_privacy      <= PRIV_OPEN;
        task_has_deadline <= 1'b0;
        task_deadline_ms  <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= ttp_pkg::CFG_HEAVY_LEVEL;
        cfg_data          <= '0;
        cur_short         = ttp_pkg::SHORT_DEADLINE_RST;
        bursty            = 1'b0;
        burst_left        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset config
        send_item(mk_task(4'd0, PRIV_OPEN, 1'b0, 16'd0));          // empty table
        send_item(mk_task(4'd0, ttp_pkg::PRIV_LOCAL_ONLY, 1'b0, 16'd0)); // empty, degrade
        send_item(mk_entry(4'd0, ttp_pkg::TIER_EDGE, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0, 4'd15));
        send_item(mk_entry(4'd1, ttp_pkg::TIER_EDGE, 1'b1, 1'b1, 1'b0, 1'b0, 7'd10, 4'd5));
        send_item(mk_entry(4'd2, ttp_pkg::TIER_HUB, 1'b1, 1'b0, 1'b0, 1'b0, 7'd100, 4'd15));
        send_item(mk_entry(4'd3, ttp_pkg::TIER_COMPUTE, 1'b1, 1'b0, 1'b0, 1'b1, 7'd50,
                           4'd15));
        send_item(mk_entry(4'd15, ttp_pkg::TIER_COMPUTE, 1'b1, 1'b1, 1'b1, 1'b0, 7'd127,
                           4'd15));
        send_item(mk_entry(4'd5, ttp_pkg::TIER_EDGE, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 4'd0));
        send_item(mk_task(4'd0, PRIV_OPEN, 1'b0, 16'd0));          // load tie, lower slot
        send_item(mk_task(4'd15, PRIV_OPEN, 1'b0, 16'd0));         // heavy, compute first
        send_item(mk_task(4'd15, ttp_pkg::PRIV_NO_EGRESS, 1'b0, 16'd0)); // shared compute
        send_item(mk_task(4'd15, ttp_pkg::PRIV_LOCAL_ONLY, 1'b0, 16'd0));
        send_item(mk_task(4'd3, PRIV_OPEN, 1'b1, 16'd0));          // short deadline
        send_item(mk_task(4'd3, PRIV_OPEN, 1'b1, 16'd49));
        send_item(mk_task(4'd3, PRIV_OPEN, 1'b1, 16'd50));
        send_item(mk_task(4'd12, PRIV_UNUSED, 1'b0, 16'hFFFF));    // unused privacy
        send_item('{mode: MODE_UNUSED, idx: 4'd0, tier: ttp_pkg::TIER_EDGE, reach: 1'b0,
                    peer: 1'b0, loc: 1'b0, shared: 1'b0, load: 7'd0, lvl: 4'd0,
                    priv: PRIV_OPEN, has_dl: 1'b0, dl: 16'd0});
        send_item('{mode: ttp_pkg::MODE_REMOVE, idx: 4'd0, tier: ttp_pkg::TIER_EDGE,
                    reach: 1'b0, peer: 1'b0, loc: 1'b0, shared: 1'b0, load: 7'd0,
                    lvl: 4'd0, priv: PRIV_OPEN, has_dl: 1'b0, dl: 16'd0});
        send_item(mk_task(4'd15, ttp_pkg::PRIV_LOCAL_ONLY, 1'b0, 16'd0)); // local node only on a denied tier
        send_item(mk_entry(4'd4, TIER_OTHER, 1'b1, 1'b0, 1'b1, 1'b0, 7'd120, 4'd0));
        send_item(mk_task(4'd15, ttp_pkg::PRIV_LOCAL_ONLY, 1'b0, 16'd0)); // other tier
        send_item(mk_task(4'd9, PRIV_OPEN, 1'b1, 16'd10));         // degrade to local
        send_item(mk_task(4'd15, PRIV_OPEN, 1'b0, 16'd0));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            if (p >= 4)
            begin
                heavy_set[p] = 4'($urandom_range(0, 15));
                short_set[p] = 16'($urandom_range(0, 300));
            end
            apply_settings(heavy_set[p], short_set[p]);
            bursty     = (p != 2);
            burst_left = $urandom_range(0, 8);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(random_item());
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hdl/ttp_pkg.sv
hdl/ttp_cell.sv
hdl/tiered_task_placement_unit.sv
dv/ttp_placement_checker.sv
dv/tiered_task_placement_unit_tb.sv
